// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the block's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define FNPC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define FNPC_ASSERT_NEVER(label, clk, rst, cond, msg) \
  `FNPC_ASSERT(label, clk, rst, !(cond), msg)

`endif

// ===== hw/rtl/fnpc_pkg.sv =====
package fnpc_pkg;

  // Configuration port
  localparam int CFG_INDEX_BITS  = 1;
  localparam int CFG_DATA_BITS   = 13;
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int RESET_WIDTH     = 1024;
  localparam int RESET_HEIGHT    = 1024;

  // Row counter and the tallest frame it covers
  localparam int ROW_BITS   = 12;
  localparam int MAX_HEIGHT = 4096;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_FRAME_WIDTH  = 1'b0;
  localparam cfg_index_t REG_FRAME_HEIGHT = 1'b1;

  // Request opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Per-request control handed from the counters to the filter stage
  typedef struct packed {
    logic emit;
    logic has_up;
    logic has_down;
    logic has_left;
    logic has_right;
    logic last;
    logic swap;
  } fnpc_tag_t;

endpackage

// ===== hw/rtl/fnpc_in_if.sv =====
interface fnpc_in_if #(
  parameter int PIXEL_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [PIXEL_BITS-1:0] pixel_in;

  modport source (output valid, output opcode, output pixel_in, input ready);
  modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

// ===== hw/rtl/fnpc_out_if.sv =====
interface fnpc_out_if #(
  parameter int PIXEL_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  last_of_frame;

  modport source (output valid, output pixel_out, output last_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

// ===== hw/rtl/fnpc_line_ram.sv =====
module fnpc_line_ram #(
  parameter int DEPTH     = 1024,
  parameter int DATA_BITS = 16,
  localparam int AW       = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr0,
  input  logic [AW-1:0]        rd_addr1,
  output logic [DATA_BITS-1:0] rd_data0,
  output logic [DATA_BITS-1:0] rd_data1,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [DATA_BITS-1:0] wr_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  // Read returns the old entry when the same address is written in that cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule

// ===== hw/rtl/fnpc_ctrl.sv =====
`include "assert_macros.svh"

module fnpc_ctrl #(
  parameter int MAX_WIDTH = 1024,
  localparam int AW       = $clog2(MAX_WIDTH)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  fnpc_pkg::cfg_index_t               cfg_index,
  input  logic [fnpc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                               accept,
  input  logic                               opcode,
  output logic [AW-1:0]                      rd_addr0,
  output logic [AW-1:0]                      rd_addr1,
  output logic                               wr_en_a,
  output logic                               wr_en_b,
  output fnpc_pkg::fnpc_tag_t                tag
);
  import fnpc_pkg::*;

  logic [WIDTH_REG_BITS-1:0]  frame_width;
  logic [HEIGHT_REG_BITS-1:0] frame_height;

  logic [AW-1:0]       column_count;
  logic [ROW_BITS-1:0] row_count;
  logic                store_swap;
  logic                draining;

  logic [AW:0]                eff_w;
  logic [AW:0]                w_last;
  logic [AW-1:0]              col;
  logic [AW:0]                col_plus1;
  logic                       col_last;
  logic [HEIGHT_REG_BITS-1:0] eff_h;
  logic [HEIGHT_REG_BITS-1:0] row_plus1;
  logic                       row_last;
  logic                       row_ge1;
  logic                       row_ge2;
  logic                       is_pixel;
  logic                       is_drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_REG_BITS'(RESET_WIDTH);
      frame_height <= HEIGHT_REG_BITS'(RESET_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[WIDTH_REG_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[HEIGHT_REG_BITS-1:0];
      endcase
    end
  end

  // Clamp the programmed sizes into the supported range.
  always_comb begin
    if (frame_width == '0) begin
      eff_w = (AW+1)'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      eff_w = (AW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (AW+1)'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = HEIGHT_REG_BITS'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      eff_h = HEIGHT_REG_BITS'(MAX_HEIGHT);
    end else begin
      eff_h = frame_height;
    end
  end

  // A column at or past the row end saturates to the last column.
  assign w_last    = eff_w - 1'b1;
  assign col       = ({1'b0, column_count} >= eff_w) ? w_last[AW-1:0] : column_count;
  assign col_plus1 = {1'b0, col} + 1'b1;
  assign col_last  = (col_plus1 >= eff_w);
  assign row_plus1 = {1'b0, row_count} + 1'b1;
  assign row_last  = (row_plus1 >= eff_h);
  assign row_ge1   = (row_count != '0);
  assign row_ge2   = (row_count > ROW_BITS'(1));

  // Pixels are dropped while draining; drain steps are dropped otherwise.
  assign is_pixel = accept && (opcode == OP_PIXEL) && !draining;
  assign is_drain = accept && (opcode == OP_DRAIN) && draining;

  assign rd_addr0 = col;
  assign rd_addr1 = col_last ? col : col_plus1[AW-1:0];
  assign wr_en_a  = is_pixel && store_swap;
  assign wr_en_b  = is_pixel && !store_swap;

  always_comb begin
    tag.emit      = (is_pixel && row_ge1) || is_drain;
    tag.has_up    = draining ? row_ge1 : row_ge2;
    tag.has_down  = !draining;
    tag.has_left  = (col != '0);
    tag.has_right = !col_last;
    tag.last      = draining && col_last;
    tag.swap      = store_swap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      store_swap   <= 1'b0;
      draining     <= 1'b0;
    end else if (is_pixel) begin
      if (col_last) begin
        column_count <= '0;
        store_swap   <= ~store_swap;
        if (row_last) begin
          draining <= 1'b1;
        end else begin
          row_count <= row_plus1[ROW_BITS-1:0];
        end
      end else begin
        column_count <= col_plus1[AW-1:0];
      end
    end else if (is_drain) begin
      if (col_last) begin
        draining     <= 1'b0;
        column_count <= '0;
        row_count    <= '0;
      end else begin
        column_count <= col_plus1[AW-1:0];
      end
    end
  end

  `FNPC_ASSERT_NEVER(a_both_stores_written, clk, rst, wr_en_a && wr_en_b, "both line stores written")
  `FNPC_ASSERT(a_drain_swaps, clk, rst, $rose(draining) |-> store_swap != $past(store_swap), "drain entered without store swap")

endmodule

// ===== hw/rtl/fnpc_clamp.sv =====
`include "assert_macros.svh"

module fnpc_clamp #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  fnpc_pkg::fnpc_tag_t   tag_in,
  input  logic [PIXEL_BITS-1:0] down_in,
  input  logic [PIXEL_BITS-1:0] a_rd0,
  input  logic [PIXEL_BITS-1:0] a_rd1,
  input  logic [PIXEL_BITS-1:0] b_rd0,
  input  logic [PIXEL_BITS-1:0] b_rd1,
  output logic                  ready,
  fnpc_out_if.source            results
);
  import fnpc_pkg::*;

  logic                  s1_valid;
  fnpc_tag_t             s1_tag;
  logic [PIXEL_BITS-1:0] s1_down;
  logic [PIXEL_BITS-1:0] left_pixel;

  logic [PIXEL_BITS-1:0] centre;
  logic [PIXEL_BITS-1:0] right_pix;
  logic [PIXEL_BITS-1:0] up_pix;
  logic [PIXEL_BITS-1:0] top;
  logic [PIXEL_BITS-1:0] result;
  logic                  peak;
  logic                  out_free;
  logic                  s1_go;

  // Store selected by swap holds the previous row; the other the row above it.
  assign centre    = s1_tag.swap ? b_rd0 : a_rd0;
  assign right_pix = s1_tag.swap ? b_rd1 : a_rd1;
  assign up_pix    = s1_tag.swap ? a_rd0 : b_rd0;

  always_comb begin
    peak = 1'b1;
    top  = '0;
    if (s1_tag.has_up) begin
      if (centre <= up_pix) peak = 1'b0;
      if (up_pix > top) top = up_pix;
    end
    if (s1_tag.has_down) begin
      if (centre <= s1_down) peak = 1'b0;
      if (s1_down > top) top = s1_down;
    end
    if (s1_tag.has_left) begin
      if (centre <= left_pixel) peak = 1'b0;
      if (left_pixel > top) top = left_pixel;
    end
    if (s1_tag.has_right) begin
      if (centre <= right_pix) peak = 1'b0;
      if (right_pix > top) top = right_pix;
    end
    result = peak ? top : centre;
  end

  assign out_free = !results.valid || results.ready;
  assign s1_go    = s1_valid && out_free;
  assign ready    = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= tag_in.emit;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tag  <= tag_in;
      s1_down <= down_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
      left_pixel    <= '0;
    end else if (s1_go) begin
      results.valid <= 1'b1;
      left_pixel    <= centre;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      results.pixel_out     <= result;
      results.last_of_frame <= s1_tag.last;
    end
  end

  `FNPC_ASSERT(a_stage_holds, clk, rst, s1_valid && !out_free |=> s1_valid && $stable(s1_down) && $stable(s1_tag), "filter stage lost a stalled request")
  `FNPC_ASSERT(a_result_source, clk, rst, $rose(results.valid) |-> $past(s1_valid), "result raised without filter stage")

endmodule

// ===== hw/rtl/four_neighbour_peak_clamp_top.sv =====
// Channel   Modport  Fields                         Accepted when
// pixels    sink     opcode, pixel_in               pixels.valid && pixels.ready
// results   source   pixel_out, last_of_frame       results.valid && results.ready
// config    write    cfg_we, cfg_index, cfg_data    cfg_we high
//
// One request per clock while pixels.ready is high; a request passes the line
// memory read at the accept edge, then the filter stage into the output register.
// Reset clears counters, configuration and handshake state; line memories are not cleared.
// pixels.ready drops only while the filter stage holds a result and the
// output register is full and not being taken.
module four_neighbour_peak_clamp_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  fnpc_in_if.sink                            pixels,
  fnpc_out_if.source                         results,
  input  logic                               cfg_we,
  input  fnpc_pkg::cfg_index_t               cfg_index,
  input  logic [fnpc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import fnpc_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic                  accept;
  logic                  ready;
  logic [AW-1:0]         rd_addr0;
  logic [AW-1:0]         rd_addr1;
  logic                  wr_en_a;
  logic                  wr_en_b;
  fnpc_tag_t             tag;
  logic [PIXEL_BITS-1:0] a_rd0;
  logic [PIXEL_BITS-1:0] a_rd1;
  logic [PIXEL_BITS-1:0] b_rd0;
  logic [PIXEL_BITS-1:0] b_rd1;

  // Take a request whenever the filter stage is free or advancing.
  assign pixels.ready = ready;
  assign accept       = pixels.valid && ready;

  // Counters, configuration and line memory addressing. The arriving pixel
  // overwrites the older row at its column; the previous row is read at the
  // column and one to the right.
  fnpc_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .opcode    (pixels.opcode),
    .rd_addr0  (rd_addr0),
    .rd_addr1  (rd_addr1),
    .wr_en_a   (wr_en_a),
    .wr_en_b   (wr_en_b),
    .tag       (tag)
  );

  // Two rotating row stores. Both are read on every request; only the one
  // holding the older row is written, and a same-address read sees the old
  // value, which is the pixel above.
  fnpc_line_ram #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (PIXEL_BITS)
  ) u_store_a (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (a_rd0),
    .rd_data1 (a_rd1),
    .wr_en    (wr_en_a),
    .wr_addr  (rd_addr0),
    .wr_data  (pixels.pixel_in)
  );

  fnpc_line_ram #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (PIXEL_BITS)
  ) u_store_b (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (b_rd0),
    .rd_data1 (b_rd1),
    .wr_en    (wr_en_b),
    .wr_addr  (rd_addr0),
    .wr_data  (pixels.pixel_in)
  );

  // Filter stage and output register: compare the centre against the
  // neighbours that exist and drive the result channel.
  fnpc_clamp #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_clamp (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .tag_in  (tag),
    .down_in (pixels.pixel_in),
    .a_rd0   (a_rd0),
    .a_rd1   (a_rd1),
    .b_rd0   (b_rd0),
    .b_rd1   (b_rd1),
    .ready   (ready),
    .results (results)
  );

endmodule

// ===== sim/tb_four_neighbour_peak_clamp_top.sv =====
module tb_four_neighbour_peak_clamp_top;
  import fnpc_pkg::*;

  localparam int MAX_W = 1024;
  localparam int PIX_W = 16;

  // Kinds of row in the directed script
  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_DRAIN,
    KIND_WIDTH,
    KIND_HEIGHT
  } step_kind_e;

  typedef struct packed {
    step_kind_e       kind;
    logic [PIX_W-1:0] value;
    logic             typed;
    logic [PIX_W-1:0] exp_pix;
    logic             exp_end;
  } step_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             end_of_frame;
  } result_t;

  // Directed script: register writes and requests, walked in order. A typed
  // expectation replaces the predicted one only where the value is obvious.
  localparam int SCRIPT_LEN = 23;
  localparam step_t SCRIPT [0:SCRIPT_LEN-1] = '{
    // 1x1 frame (zero registers act as one): stray drain, lone pixel, stray
    // pixel while draining, then the drain yields 0 as a peak over nothing
    '{KIND_WIDTH,  16'd0,     1'b0, 16'd0, 1'b0},
    '{KIND_HEIGHT, 16'd0,     1'b0, 16'd0, 1'b0},
    '{KIND_DRAIN,  16'h5A5A,  1'b0, 16'd0, 1'b0},
    '{KIND_PIXEL,  16'hFFFF,  1'b0, 16'd0, 1'b0},
    '{KIND_PIXEL,  16'h1234,  1'b0, 16'd0, 1'b0},
    '{KIND_DRAIN,  16'h0000,  1'b1, 16'd0, 1'b1},
    // 3x2 frame with both pixel extremes; first row emits nothing
    '{KIND_WIDTH,  16'd3,     1'b0, 16'd0, 1'b0},
    '{KIND_HEIGHT, 16'd2,     1'b0, 16'd0, 1'b0},
    '{KIND_PIXEL,  16'd0,     1'b0, 16'd0, 1'b0},
    '{KIND_PIXEL,  16'hFFFF,  1'b0, 16'd0, 1'b0},
    '{KIND_PIXEL,  16'd100,   1'b0, 16'd0, 1'b0},
    '{KIND_PIXEL,  16'hFFFF,  1'b1, 16'd0, 1'b0},
    '{KIND_PIXEL,  16'd0,     1'b0, 16'd0, 1'b0},
    '{KIND_PIXEL,  16'd100,   1'b0, 16'd0, 1'b0},
    // full-scale centre over zero neighbours clamps to 0
    '{KIND_DRAIN,  16'hFFFF,  1'b1, 16'd0, 1'b0},
    '{KIND_DRAIN,  16'd0,     1'b0, 16'd0, 1'b0},
    '{KIND_DRAIN,  16'd0,     1'b0, 16'd0, 1'b0},
    // single-column frame: only up and down neighbours exist
    '{KIND_WIDTH,  16'd1,     1'b0, 16'd0, 1'b0},
    '{KIND_HEIGHT, 16'd3,     1'b0, 16'd0, 1'b0},
    '{KIND_PIXEL,  16'd5,     1'b0, 16'd0, 1'b0},
    '{KIND_PIXEL,  16'd9,     1'b0, 16'd0, 1'b0},
    '{KIND_PIXEL,  16'd5,     1'b0, 16'd0, 1'b0},
    '{KIND_DRAIN,  16'd0,     1'b0, 16'd0, 1'b0}
  };

  // Register extremes: each starts a frame that the next setting cuts short
  localparam int EXT_COUNT = 4;
  localparam int EXT_W [0:EXT_COUNT-1] = '{1024, 2047, 1, 1};
  localparam int EXT_H [0:EXT_COUNT-1] = '{1, 2, 4096, 8191};

  localparam int TARGET_ITEMS = 950;
  localparam int QUIET_ITEMS  = 800;
  localparam int SETTLE_CYCLES = 6;

  logic clk;
  logic rst;
  logic cfg_we;
  cfg_index_t cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  fnpc_in_if  #(.PIXEL_BITS(PIX_W)) pixels_if ();
  fnpc_out_if #(.PIXEL_BITS(PIX_W)) results_if ();

  four_neighbour_peak_clamp_top #(
    .MAX_WIDTH (MAX_W),
    .PIXEL_BITS(PIX_W)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .pixels   (pixels_if),
    .results  (results_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Filter shadow state, updated at every accepted request
  logic [PIX_W-1:0] line_a [MAX_W];
  logic [PIX_W-1:0] line_b [MAX_W];
  logic [10:0]      width_reg;
  logic [12:0]      height_reg;
  int unsigned      col_at;
  int unsigned      row_at;
  int unsigned      drain_at;
  logic             swap_sel;
  logic [PIX_W-1:0] left_px;
  logic             draining;
  int unsigned      frames_done;

  result_t awaited_pixels [$];
  result_t head;
  int      failures;
  bit      quiet;

  function automatic void reset_shadow();
    for (int i = 0; i < MAX_W; i++) begin
      line_a[i] = '0;
      line_b[i] = '0;
    end
    width_reg   = 11'(RESET_WIDTH);
    height_reg  = 13'(RESET_HEIGHT);
    col_at      = 0;
    row_at      = 0;
    drain_at    = 0;
    swap_sel    = 1'b0;
    left_px     = '0;
    draining    = 1'b0;
    frames_done = 0;
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic logic [PIX_W-1:0] prev_px(int unsigned i);
    return swap_sel ? line_b[i] : line_a[i];
  endfunction

  function automatic logic [PIX_W-1:0] older_px(int unsigned i);
    return swap_sel ? line_a[i] : line_b[i];
  endfunction

  function automatic bit frame_idle();
    return col_at == 0 && row_at == 0 && !draining;
  endfunction

  // Clamp column c of the previous row against the neighbours that exist
  function automatic logic [PIX_W-1:0] clamp_prev(int unsigned c, int unsigned w,
                                                  logic [PIX_W-1:0] up, bit has_up,
                                                  logic [PIX_W-1:0] down, bit has_down);
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] top;
    bit has_left;
    bit has_right;
    bit peak;
    centre    = prev_px(c);
    has_left  = (c > 0);
    has_right = (c + 1 < w);
    right     = has_right ? prev_px(c + 1) : '0;
    peak      = 1'b1;
    top       = '0;
    if (has_up) begin
      if (centre <= up) peak = 1'b0;
      if (up > top) top = up;
    end
    if (has_down) begin
      if (centre <= down) peak = 1'b0;
      if (down > top) top = down;
    end
    if (has_left) begin
      if (centre <= left_px) peak = 1'b0;
      if (left_px > top) top = left_px;
    end
    if (has_right) begin
      if (centre <= right) peak = 1'b0;
      if (right > top) top = right;
    end
    left_px = centre;
    return peak ? top : centre;
  endfunction

  // Advance the shadow by one request; return 1 when it yields a pixel
  function automatic bit predict_filter(input logic op, input logic [PIX_W-1:0] pix,
                                        output result_t res);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    bit emit;
    w    = eff_width();
    h    = eff_height();
    emit = 1'b0;
    res  = '0;
    if (op == OP_PIXEL) begin
      if (draining) return 1'b0;
      c = (col_at >= w) ? w - 1 : col_at;
      if (row_at >= 1) begin
        res.pix = clamp_prev(c, w, older_px(c), row_at >= 2, pix, 1'b1);
        emit    = 1'b1;
      end
      if (swap_sel) line_a[c] = pix;
      else line_b[c] = pix;
      if (c + 1 >= w) begin
        col_at   = 0;
        swap_sel = ~swap_sel;
        if (row_at + 1 >= h) begin
          draining = 1'b1;
          drain_at = 0;
        end else begin
          row_at = row_at + 1;
        end
      end else begin
        col_at = c + 1;
      end
      return emit;
    end
    if (!draining) return 1'b0;
    c = (drain_at >= w) ? w - 1 : drain_at;
    res.pix          = clamp_prev(c, w, older_px(c), row_at >= 1, '0, 1'b0);
    res.end_of_frame = (c + 1 >= w);
    if (c + 1 >= w) begin
      draining    = 1'b0;
      drain_at    = 0;
      col_at      = 0;
      row_at      = 0;
      frames_done = frames_done + 1;
    end else begin
      drain_at = c + 1;
    end
    return 1'b1;
  endfunction

  // Mostly tiny values so ties and peaks are common, plus the extremes
  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return PIX_W'($urandom);
      default: return PIX_W'($urandom_range(0, 7));
    endcase
  endfunction

  // Offer one request, hold it until taken, then record what it yields
  task automatic send_request(input logic op, input logic [PIX_W-1:0] pix,
                              input bit typed, input result_t typed_res);
    result_t res;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      pixels_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    pixels_if.valid    <= 1'b1;
    pixels_if.opcode   <= op;
    pixels_if.pixel_in <= pix;
    do @(posedge clk); while (!pixels_if.ready);
    if (predict_filter(op, pix, res)) awaited_pixels.push_back(typed ? typed_res : res);
  endtask

  // Drop valid and let the block run dry before touching registers
  task automatic settle();
    pixels_if.valid <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leave the write enable high; the caller lowers it after the last write
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_FRAME_WIDTH) width_reg = data[10:0];
    else height_reg = data;
  endtask

  // Stimulus and prediction
  initial begin : stimulus
    result_t     typed_res;
    bit          cfg_open;
    int unsigned frame_items;
    int unsigned ext_i;
    int unsigned new_w;
    int unsigned new_h;
    int unsigned sel;
    int unsigned budget;
    int unsigned frames_seen;
    bit          extreme;
    bit          after_ext;
    bit          noise;
    logic        op;

    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_FRAME_WIDTH;
    cfg_data           <= '0;
    pixels_if.valid    <= 1'b0;
    pixels_if.opcode   <= OP_PIXEL;
    pixels_if.pixel_in <= '0;
    failures    = 0;
    quiet       = 1'b0;
    cfg_open    = 1'b0;
    frame_items = 0;
    ext_i       = 0;
    after_ext   = 1'b0;
    reset_shadow();

    // Hold reset once, then release it
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed script
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      case (SCRIPT[i].kind)
        KIND_WIDTH, KIND_HEIGHT: begin
          if (!cfg_open) settle();
          write_reg(SCRIPT[i].kind == KIND_WIDTH ? REG_FRAME_WIDTH : REG_FRAME_HEIGHT,
                    SCRIPT[i].value[CFG_DATA_BITS-1:0]);
          cfg_open = 1'b1;
        end
        default: begin
          if (cfg_open) begin
            cfg_we   <= 1'b0;
            cfg_open = 1'b0;
          end
          typed_res.pix          = SCRIPT[i].exp_pix;
          typed_res.end_of_frame = SCRIPT[i].exp_end;
          send_request(SCRIPT[i].kind == KIND_DRAIN ? OP_DRAIN : OP_PIXEL,
                       SCRIPT[i].value, SCRIPT[i].typed, typed_res);
        end
      endcase
    end

    // Random phases: a new setting, then mostly whole frames of random content
    // with stray requests mixed in; some phases stop mid-frame and the next
    // setting lands inside the frame. An extreme setting runs only a few
    // requests, then the next phase rewrites both registers with a small
    // frame. Widen only between frames, so no read ever reaches a store
    // entry that was never written.
    typed_res = '0;
    while (frame_items < TARGET_ITEMS) begin
      extreme = 1'b0;
      if (ext_i < EXT_COUNT && frame_items >= 100 + 150 * ext_i && frame_idle()) begin
        new_w   = EXT_W[ext_i];
        new_h   = EXT_H[ext_i];
        extreme = 1'b1;
        ext_i   = ext_i + 1;
        sel     = 3;
      end else begin
        case ($urandom_range(0, 9))
          0:       new_w = 0;
          1:       new_w = $urandom_range(9, 40);
          default: new_w = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 9))
          0:       new_h = 0;
          1:       new_h = $urandom_range(7, 12);
          default: new_h = $urandom_range(1, 6);
        endcase
        if (!frame_idle()) new_w = $urandom_range(1, eff_width() < 8 ? eff_width() : 8);
        sel = after_ext ? 3 : $urandom_range(1, 3);
      end
      after_ext = extreme;

      settle();
      if (sel[0]) write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(new_w));
      if (sel[1]) write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(new_h));
      cfg_we <= 1'b0;

      if (extreme) budget = $urandom_range(3, 8);
      else if ($urandom_range(0, 6) == 0) budget = $urandom_range(1, 12);
      else budget = 32'hFFFF_FFFF;
      frames_seen = frames_done;
      do begin
        op    = draining ? OP_DRAIN : OP_PIXEL;
        noise = !extreme && $urandom_range(0, 15) == 0;
        if (noise) op = ~op;
        send_request(op, random_pixel(), 1'b0, typed_res);
        frame_items = frame_items + 1;
        budget = budget - 1;
        quiet  = frame_items >= QUIET_ITEMS;
      end while (frames_done == frames_seen && budget != 0);
    end

    // Wait for the last results, then report
    settle();
    if (failures == 0) begin
      $display("tb_four_neighbour_peak_clamp_top OK");
    end else begin
      $display("tb_four_neighbour_peak_clamp_top NOT OK");
    end
    $finish;
  end

  // Receiver pacing: short random stalls, plus a long hold now and then so
  // the block fills up and drops pixels.ready while requests keep coming
  initial begin : sink_pacing
    int stall_left;
    int taken;
    int next_squeeze;
    stall_left   = 0;
    taken        = 0;
    next_squeeze = 150;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (results_if.valid && results_if.ready) taken++;
      if (!quiet && taken >= next_squeeze) begin
        stall_left   = 80;
        next_squeeze = next_squeeze + 450;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      results_if.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Compare each taken result with the oldest expected one
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      if (awaited_pixels.size() == 0) begin
        $error("unexpected result: pixel_out=%0d last_of_frame=%0d",
               results_if.pixel_out, results_if.last_of_frame);
        failures++;
      end else begin
        head = awaited_pixels.pop_front();
        if (results_if.pixel_out !== head.pix) begin
          $error("pixel_out: expected %0d, got %0d", head.pix, results_if.pixel_out);
          failures++;
        end
        if (results_if.last_of_frame !== head.end_of_frame) begin
          $error("last_of_frame: expected %0d, got %0d", head.end_of_frame,
                 results_if.last_of_frame);
          failures++;
        end
      end
    end
  end

  // Give up well beyond the slowest legal run
  initial begin
    #60000000;
    $display("tb_four_neighbour_peak_clamp_top NOT OK");
    $finish;
  end

endmodule
